FILE: rtl/axi_initiator_transaction_tracker_assert.svh
// Assertion macros for the transaction tracker.
`ifndef AXI_INITIATOR_TRANSACTION_TRACKER_ASSERT_SVH
`define AXI_INITIATOR_TRANSACTION_TRACKER_ASSERT_SVH
// Implication that must hold each clock out of reset.
`define AITT_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication.
`define AITT_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

FILE: rtl/aitt_pkg.sv
// Types and codes shared by the transaction tracker.
package aitt_pkg;
  localparam logic [2:0] MODE_SUB_RD = 3'd0;
  localparam logic [2:0] MODE_SUB_WR = 3'd1;
  localparam logic [2:0] MODE_AR     = 3'd2;
  localparam logic [2:0] MODE_AW     = 3'd3;
  localparam logic [2:0] MODE_BRESP  = 3'd4;
  localparam logic [2:0] MODE_RBEAT  = 3'd5;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_ISSUED   = 3'd2;
  localparam logic [2:0] ST_NO_ISSUE = 3'd3;
  localparam logic [2:0] ST_WDONE    = 3'd4;
  localparam logic [2:0] ST_RBEAT    = 3'd5;
  localparam logic [2:0] ST_PERR     = 3'd6;

  localparam logic [1:0] RESP_SLVERR = 2'd2;

  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] ord;
    logic [8:0]  beats;
    logic [3:0]  id;
    logic [3:0]  qos;
    logic [2:0]  size;
  } burst_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ordinal;
    logic [7:0]  beat_index;
    logic [1:0]  resp;
    logic        last;
    logic        is_read;
    logic [47:0] addr;
    logic [8:0]  beats;
    logic [3:0]  id;
    logic [3:0]  qos;
    logic [2:0]  size;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;
endpackage

FILE: rtl/axi_initiator_transaction_tracker.sv
// Top level of the AXI initiator transaction tracker.
// Usage: one initiator event per input item (submit read/write, address
// accepted, write response, read beat); every item yields one result item.
// Input channel in_valid/in_ready, result channel out_valid/out_ready.
// bus_size_log2 is written by cfg_we/cfg_wdata, reset value 5; the user must
// write it only while idle, which the block does not enforce. Submits go
// from acceptance to S_OUT; write issue, write response, read beats of an
// active burst and unused modes pass S_EXEC first (queue memory read, then
// update and result register). Mode 2 (read issue) and a read beat that
// opens a new burst first pass S_SCAN, a scan of the outstanding read
// table, one entry per cycle. One item is in flight at a time; the next
// item is taken when the result register is free or being taken. Queue
// and write-order stores live in synchronous RAMs with registered read
// data; per-ID counters, read heads and table valid bits are flops.
// Reset empties all queues and tables and zeroes the ordinal counter; no
// clearing pass is needed. A stalled receiver holds the result register
// and blocks intake until it is taken.
module axi_initiator_transaction_tracker
  import aitt_pkg::*;
#(
  parameter int READ_QUEUE_DEPTH  = 8,
  parameter int WRITE_QUEUE_DEPTH = 8,
  parameter int ID_COUNT          = 16,
  parameter int MAX_READS_OUT     = 16,
  parameter int WRITES_PER_ID     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [47:0] in_address,
  input  logic [8:0]  in_beat_count,
  input  logic [3:0]  in_axi_id,
  input  logic [3:0]  in_qos,
  input  logic [1:0]  in_resp,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_ordinal,
  output logic [7:0]  out_beat_index,
  output logic [1:0]  out_resp_out,
  output logic        out_last_out,
  output logic        out_is_read,
  output logic [47:0] out_address_out,
  output logic [8:0]  out_beats_out,
  output logic [3:0]  out_id_out,
  output logic [3:0]  out_qos_out,
  output logic [2:0]  out_size_out
);
  localparam int RQW = (READ_QUEUE_DEPTH > 1) ? $clog2(READ_QUEUE_DEPTH) : 1;
  localparam int WQW = (WRITE_QUEUE_DEPTH > 1) ? $clog2(WRITE_QUEUE_DEPTH) : 1;
  localparam int RCW = $clog2(READ_QUEUE_DEPTH + 1);
  localparam int WCW = $clog2(WRITE_QUEUE_DEPTH + 1);
  localparam int SLW = (MAX_READS_OUT > 1) ? $clog2(MAX_READS_OUT) : 1;
  localparam int SCW = $clog2(MAX_READS_OUT + 1);
  localparam int WPW = (WRITES_PER_ID > 1) ? $clog2(WRITES_PER_ID) : 1;
  localparam int WOW = $clog2(WRITES_PER_ID + 1);
  localparam int IDS = (ID_COUNT < 16) ? ID_COUNT : 16;
  localparam int IXW = (IDS > 1) ? $clog2(IDS) : 1;
  localparam int WOA = (IDS * WRITES_PER_ID > 1) ? $clog2(IDS * WRITES_PER_ID) : 1;

  // memories
  burst_t      rq_mem [READ_QUEUE_DEPTH];
  burst_t      wq_mem [WRITE_QUEUE_DEPTH];
  logic [31:0] wo_mem [IDS*WRITES_PER_ID];
  burst_t      rq_rd, wq_rd;
  logic [31:0] wo_rd;

  // outstanding read table
  logic [MAX_READS_OUT-1:0] ot_valid_r;
  logic [31:0] ot_ord_r   [MAX_READS_OUT];
  logic [3:0]  ot_id_r    [MAX_READS_OUT];
  logic [8:0]  ot_beats_r [MAX_READS_OUT];

  logic [RQW-1:0] rq_head_r;
  logic [RCW-1:0] rq_cnt_r;
  logic [WQW-1:0] wq_head_r;
  logic [WCW-1:0] wq_cnt_r;
  logic [WPW-1:0] wo_head_r [IDS];
  logic [WOW-1:0] wo_cnt_r  [IDS];
  logic [IDS-1:0] rh_act_r;
  logic [31:0]    rh_ord_r   [IDS];
  logic [8:0]     rh_seen_r  [IDS];
  logic [8:0]     rh_total_r [IDS];
  logic [SLW-1:0] rh_slot_r  [IDS];
  logic [31:0]    next_ord_r;
  logic [2:0]     size_r;

  state_t state_r;
  logic [2:0]  mode_r;
  logic [3:0]  id_r;
  logic [1:0]  resp_r;
  logic        last_r;
  logic [SCW-1:0] scan_r;
  logic        found_r;
  logic [SLW-1:0] best_r;
  logic [31:0] best_age_r;
  result_t res_r;
  logic    out_valid_r;

  logic accept, out_free;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  logic [IXW-1:0] in_ix, id_ix, wid_ix;
  assign in_ix  = in_axi_id[IXW-1:0];
  assign id_ix  = id_r[IXW-1:0];
  assign wid_ix = wq_rd.id[IXW-1:0];
  logic in_id_ok, id_ok, wid_ok;
  assign in_id_ok = {28'd0, in_axi_id} < ID_COUNT;
  assign id_ok    = {28'd0, id_r} < ID_COUNT;
  assign wid_ok   = {28'd0, wq_rd.id} < ID_COUNT;

  // read address for the write-order RAM: current head of the response ID
  logic [WOA-1:0] wo_raddr, wo_waddr;
  logic [WPW-1:0] wo_tail;
  logic [31:0]    wo_sum;
  always_comb begin
    wo_raddr = '0;
    if (in_id_ok)
      wo_raddr = WOA'(32'(in_ix) * WRITES_PER_ID + 32'(wo_head_r[in_ix]));
    wo_sum = 32'(wo_head_r[wid_ix]) + 32'(wo_cnt_r[wid_ix]);
    wo_tail = WPW'((wo_sum >= WRITES_PER_ID) ? wo_sum - WRITES_PER_ID : wo_sum);
    wo_waddr = WOA'(32'(wid_ix) * WRITES_PER_ID + 32'(wo_tail));
  end

  always_ff @(posedge clk) begin
    rq_rd <= rq_mem[rq_head_r];
    wq_rd <= wq_mem[wq_head_r];
    wo_rd <= wo_mem[wo_raddr];
  end

  burst_t new_b;
  always_comb begin
    new_b.addr  = in_address;
    new_b.ord   = next_ord_r;
    new_b.beats = in_beat_count;
    new_b.id    = in_axi_id;
    new_b.qos   = in_qos;
    new_b.size  = size_r;
  end
  logic [RQW-1:0] rq_tail;
  logic [WQW-1:0] wq_tail;
  logic [31:0]    rq_sum, wq_sum;
  assign rq_sum  = 32'(rq_head_r) + 32'(rq_cnt_r);
  assign wq_sum  = 32'(wq_head_r) + 32'(wq_cnt_r);
  assign rq_tail = RQW'((rq_sum >= READ_QUEUE_DEPTH) ? rq_sum - READ_QUEUE_DEPTH : rq_sum);
  assign wq_tail = WQW'((wq_sum >= WRITE_QUEUE_DEPTH) ? wq_sum - WRITE_QUEUE_DEPTH : wq_sum);
  logic rq_wr, wq_wr, wo_wr;
  assign rq_wr = accept && in_mode == MODE_SUB_RD && 32'(rq_cnt_r) < READ_QUEUE_DEPTH;
  assign wq_wr = accept && in_mode == MODE_SUB_WR && 32'(wq_cnt_r) < WRITE_QUEUE_DEPTH;

  always_ff @(posedge clk) begin
    if (rq_wr) rq_mem[rq_tail] <= new_b;
    if (wq_wr) wq_mem[wq_tail] <= new_b;
    if (wo_wr) wo_mem[wo_waddr] <= wq_rd.ord;
  end

  // result seed at acceptance: submits are complete, other modes fill in later
  result_t res_acc;
  always_comb begin
    res_acc = '0;
    if (in_mode == MODE_SUB_RD || in_mode == MODE_SUB_WR) begin
      if (rq_wr || wq_wr) begin
        res_acc.status  = ST_ACCEPTED;
        res_acc.ordinal = next_ord_r;
      end else begin
        res_acc.status = ST_FULL;
      end
    end
  end

  // scan element
  logic [SLW-1:0] sc_ix;
  logic [31:0]    sc_age;
  assign sc_ix  = scan_r[SLW-1:0];
  assign sc_age = ot_ord_r[sc_ix] - next_ord_r;

  logic aw_ok;
  assign aw_ok = mode_r == MODE_AW && state_r == S_EXEC && wq_cnt_r != '0 && wid_ok &&
                 32'(wo_cnt_r[wid_ix]) < WRITES_PER_ID;
  assign wo_wr = aw_ok;

  // read beat step for an active head (either already active or just found)
  logic [8:0] rb_seen;
  logic [8:0] rb_total;
  logic [31:0] rb_ord;
  logic [SLW-1:0] rb_slot;
  always_comb begin
    if (rh_act_r[id_ix]) begin
      rb_seen = rh_seen_r[id_ix] + 9'd1; rb_total = rh_total_r[id_ix];
      rb_ord = rh_ord_r[id_ix]; rb_slot = rh_slot_r[id_ix];
    end else begin
      rb_seen = 9'd1; rb_total = ot_beats_r[best_r];
      rb_ord = ot_ord_r[best_r]; rb_slot = best_r;
    end
  end
  logic rb_err, rb_done;
  assign rb_err  = rb_seen > rb_total || (last_r && rb_seen != rb_total);
  assign rb_done = last_r || rb_seen >= rb_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0; size_r <= 3'd5;
      rq_head_r <= '0; rq_cnt_r <= '0; wq_head_r <= '0; wq_cnt_r <= '0;
      ot_valid_r <= '0; rh_act_r <= '0; next_ord_r <= '0;
      for (int i = 0; i < IDS; i++) begin
        wo_head_r[i] <= '0; wo_cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) size_r <= cfg_wdata;
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept) begin
          mode_r <= in_mode;
          id_r <= in_axi_id; resp_r <= in_resp; last_r <= in_last;
          scan_r <= '0; found_r <= 1'b0; best_r <= '0; best_age_r <= '0;
          if (rq_wr) rq_cnt_r <= rq_cnt_r + 1'b1;
          if (wq_wr) wq_cnt_r <= wq_cnt_r + 1'b1;
          if (rq_wr || wq_wr) next_ord_r <= next_ord_r + 32'd1;
          res_r <= res_acc;
          if (in_mode == MODE_SUB_RD || in_mode == MODE_SUB_WR)
            state_r <= S_OUT;
          else if (in_mode == MODE_AR ||
                   (in_mode == MODE_RBEAT && in_id_ok && !rh_act_r[in_ix]))
            state_r <= S_SCAN;
          else
            state_r <= S_EXEC;
        end
        S_SCAN: begin
          if (32'(scan_r) == MAX_READS_OUT) state_r <= S_EXEC;
          else begin
            scan_r <= scan_r + 1'b1;
            if (mode_r == MODE_AR) begin
              if (!found_r && !ot_valid_r[sc_ix]) begin found_r <= 1'b1; best_r <= sc_ix; end
            end else if (ot_valid_r[sc_ix] && ot_id_r[sc_ix] == id_r &&
                         (!found_r || sc_age < best_age_r)) begin
              found_r <= 1'b1; best_r <= sc_ix; best_age_r <= sc_age;
            end
          end
        end
        S_EXEC: begin
          state_r <= S_OUT;
          priority case (mode_r)
            MODE_AR: begin
              res_r.is_read <= 1'b1;
              if (rq_cnt_r == '0 || !found_r) res_r.status <= ST_NO_ISSUE;
              else begin
                res_r.status <= ST_ISSUED; res_r.ordinal <= rq_rd.ord;
                res_r.addr <= rq_rd.addr; res_r.beats <= rq_rd.beats;
                res_r.id <= rq_rd.id; res_r.qos <= rq_rd.qos; res_r.size <= rq_rd.size;
                ot_valid_r[best_r] <= 1'b1; ot_ord_r[best_r] <= rq_rd.ord;
                ot_id_r[best_r] <= rq_rd.id; ot_beats_r[best_r] <= rq_rd.beats;
                rq_head_r <= (32'(rq_head_r) == READ_QUEUE_DEPTH - 1) ? '0 :
                             rq_head_r + 1'b1;
                rq_cnt_r <= rq_cnt_r - 1'b1;
              end
            end
            MODE_AW: begin
              if (!aw_ok) res_r.status <= ST_NO_ISSUE;
              else begin
                res_r.status <= ST_ISSUED; res_r.ordinal <= wq_rd.ord;
                res_r.addr <= wq_rd.addr; res_r.beats <= wq_rd.beats;
                res_r.id <= wq_rd.id; res_r.qos <= wq_rd.qos; res_r.size <= wq_rd.size;
                wo_cnt_r[wid_ix] <= wo_cnt_r[wid_ix] + 1'b1;
                wq_head_r <= (32'(wq_head_r) == WRITE_QUEUE_DEPTH - 1) ? '0 :
                             wq_head_r + 1'b1;
                wq_cnt_r <= wq_cnt_r - 1'b1;
              end
            end
            MODE_BRESP: begin
              if (!id_ok || wo_cnt_r[id_ix] == '0) res_r.status <= ST_PERR;
              else begin
                res_r.status <= ST_WDONE; res_r.ordinal <= wo_rd; res_r.resp <= resp_r;
                wo_head_r[id_ix] <= (32'(wo_head_r[id_ix]) == WRITES_PER_ID - 1) ? '0 :
                                    wo_head_r[id_ix] + 1'b1;
                wo_cnt_r[id_ix] <= wo_cnt_r[id_ix] - 1'b1;
              end
            end
            MODE_RBEAT: begin
              if (!id_ok || (!rh_act_r[id_ix] && !found_r)) begin
                res_r.status <= ST_PERR; res_r.is_read <= 1'b1;
              end else begin
                res_r.status <= ST_RBEAT; res_r.ordinal <= rb_ord;
                res_r.beat_index <= rb_seen[7:0] - 8'd1;
                res_r.resp <= rb_err ? RESP_SLVERR : resp_r; res_r.last <= last_r;
                rh_ord_r[id_ix] <= rb_ord; rh_seen_r[id_ix] <= rb_seen;
                rh_total_r[id_ix] <= rb_total; rh_slot_r[id_ix] <= rb_slot;
                rh_act_r[id_ix] <= !rb_done;
                if (rb_done) ot_valid_r[rb_slot] <= 1'b0;
              end
            end
            default: res_r.status <= ST_PERR;
          endcase
        end
        S_OUT: if (out_free) begin
          out_valid_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_ordinal     = res_r.ordinal;
  assign out_beat_index  = res_r.beat_index;
  assign out_resp_out    = res_r.resp;
  assign out_last_out    = res_r.last;
  assign out_is_read     = res_r.is_read;
  assign out_address_out = res_r.addr;
  assign out_beats_out   = res_r.beats;
  assign out_id_out      = res_r.id;
  assign out_qos_out     = res_r.qos;
  assign out_size_out    = res_r.size;

`include "axi_initiator_transaction_tracker_assert.svh"
  `AITT_ASSERT_IMP(a_ready_idle, in_ready, state_r == S_IDLE)
  `AITT_ASSERT_NXT(a_accept_busy, accept, state_r != S_IDLE)
  `AITT_ASSERT_IMP(a_rq_bound, 1'b1, 32'(rq_cnt_r) <= READ_QUEUE_DEPTH)
  `AITT_ASSERT_NXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(out_ordinal))
endmodule
